### rtl/core/shac_pkg.sv
// Shared types and constants for the SMART attribute health check block.
package shac_pkg;

	localparam int unsigned ID_W        = 8;
	localparam int unsigned VAL_W       = 8;
	localparam int unsigned RAW_W       = 48;
	localparam int unsigned RULE_W      = 57;
	localparam int unsigned RULE_SLOTS  = 4;
	localparam int unsigned RULE_IDX_W  = $clog2(RULE_SLOTS);
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CUSTOM_RULES_DEF = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RULE_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RULE_3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_USE_VENDOR = 3'd5;

	localparam logic [ID_W-1:0] ID_POWER_ON_HOURS = 8'h09;
	localparam logic [ID_W-1:0] ID_TEMP_A         = 8'hC2;
	localparam logic [ID_W-1:0] ID_TEMP_B         = 8'hBE;
	localparam logic [ID_W-1:0] ID_TEMP_C         = 8'hE7;
	localparam logic [ID_W-1:0] ID_REALLOC        = 8'h05;
	localparam logic [ID_W-1:0] ID_PENDING        = 8'hC5;
	localparam logic [ID_W-1:0] ID_UNCORRECT      = 8'hC6;
	localparam logic [ID_W-1:0] ID_REPORTED_UNC   = 8'hBB;
	localparam logic [ID_W-1:0] ID_END_TO_END     = 8'hB8;
	localparam logic [ID_W-1:0] ID_SPIN_RETRY     = 8'h0A;
	localparam logic [ID_W-1:0] ID_REALLOC_EVENT  = 8'hC4;

	localparam logic [RAW_W-1:0] RAW_CUT_MASK     = 48'h0000_FFFF_FFFF;
	localparam logic [VAL_W-1:0] TEMP_LIMIT_RST   = 8'd60;

	typedef struct packed {
		logic             en;
		logic [ID_W-1:0]  id;
		logic [RAW_W-1:0] limit;
	} rule_t;

	typedef struct packed {
		rule_t [RULE_SLOTS-1:0] rule;
		logic [VAL_W-1:0]       temp_limit;
		logic                   use_vendor;
	} cfg_t;

	typedef struct packed {
		logic attr_fail;
		logic last;
	} q_word_t;

	typedef struct packed {
		logic    valid;
		q_word_t word;
	} q_port_t;

endpackage

### rtl/core/shac_front.sv
// Front stage: judges each attribute against the rules and registers the verdict.
module shac_front #(
	parameter int unsigned CUSTOM_RULES = shac_pkg::CUSTOM_RULES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  shac_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [shac_pkg::ID_W-1:0]   attr_id,
	input  logic [shac_pkg::VAL_W-1:0]  norm_value,
	input  logic [shac_pkg::VAL_W-1:0]  vendor_limit,
	input  logic [shac_pkg::RAW_W-1:0]  raw_count,
	input  logic                        critical,
	input  logic                        last_attr,
	output shac_pkg::q_port_t           push,
	input  logic                        q_full
);
	import shac_pkg::*;

	logic [RAW_W-1:0]        raw_eff;
	logic [CUSTOM_RULES-1:0] rule_hit;
	logic                    custom_fail;
	logic                    is_temp;
	logic                    is_wear;
	logic                    attr_fail;
	logic                    advance;
	logic                    valid_s1;
	logic                    fail_s1;
	logic                    last_s1;

	always_comb begin
		raw_eff = (attr_id == ID_POWER_ON_HOURS) ? (raw_count & RAW_CUT_MASK) : raw_count;
		for (int i = 0; i < CUSTOM_RULES; i++) begin
			rule_hit[i] = cfg.rule[i].en && (cfg.rule[i].id == attr_id) &&
				(raw_eff > cfg.rule[i].limit);
		end
		custom_fail = |rule_hit;
		is_temp = attr_id inside {ID_TEMP_A, ID_TEMP_B, ID_TEMP_C};
		is_wear = attr_id inside {ID_REALLOC, ID_PENDING, ID_UNCORRECT, ID_REPORTED_UNC,
			ID_END_TO_END, ID_SPIN_RETRY, ID_REALLOC_EVENT};
		if (custom_fail) begin
			attr_fail = 1'b1;
		end else if (is_temp) begin
			attr_fail = (raw_eff[VAL_W-1:0] >= cfg.temp_limit);
		end else begin
			attr_fail = (critical && is_wear && (raw_eff != '0)) ||
				(cfg.use_vendor && (vendor_limit != '0) && (norm_value <= vendor_limit));
		end
	end

	assign advance  = !valid_s1 || !q_full;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			fail_s1 <= attr_fail;
			last_s1 <= last_attr;
		end
	end

	assign push.valid          = valid_s1;
	assign push.word.attr_fail = fail_s1;
	assign push.word.last      = last_s1;

endmodule

### rtl/core/shac_queue.sv
// Short queue of judged words between the front and back stages.
module shac_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  shac_pkg::q_port_t push,
	output logic              full,
	output shac_pkg::q_port_t head,
	input  logic              take
);
	import shac_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	q_word_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head.valid = (count_q != '0);
	assign head.word  = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = head.valid && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.word;
		end
	end

endmodule

### rtl/core/shac_back.sv
// Back stage: folds verdicts into the sticky disk flag and drives the result register.
module shac_back (
	input  logic              clk,
	input  logic              arst_n,
	input  shac_pkg::q_port_t head,
	output logic              take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              attr_verdict,
	output logic              disk_status,
	output logic              is_final
);
	import shac_pkg::*;

	logic out_valid_q;
	logic any_failed_q;
	logic attr_verdict_q;
	logic disk_status_q;
	logic is_final_q;
	logic load;

	assign take = !out_valid_q || !out_stall;
	assign load = head.valid && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			any_failed_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q  <= 1'b1;
				any_failed_q <= head.word.last ? 1'b0 : (any_failed_q | head.word.attr_fail);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			attr_verdict_q <= head.word.attr_fail;
			disk_status_q  <= head.word.last && (any_failed_q | head.word.attr_fail);
			is_final_q     <= head.word.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign attr_verdict = attr_verdict_q;
	assign disk_status  = disk_status_q;
	assign is_final     = is_final_q;

endmodule

### rtl/core/smart_attribute_health_check.sv
// Top level of the SMART attribute health check: rule registers, front, queue and back.
// One attribute word is taken per clock cycle and one result word leaves per cycle
// when the output is not stalled; a word's result passes through the front judge
// register, a queue slot and the output register, in that order. The CUSTOM_RULES
// rule comparators (four by default) run side by side in the front stage, and the
// sticky disk flag in the back stage is updated once per result, so a new attribute
// can be taken every cycle while the output is not stalled.
// Rule registers are written through the configuration port, which is always ready.
module smart_attribute_health_check #(
	parameter int unsigned CUSTOM_RULES = shac_pkg::CUSTOM_RULES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [shac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [shac_pkg::RULE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [shac_pkg::ID_W-1:0]      attr_id,
	input  logic [shac_pkg::VAL_W-1:0]     norm_value,
	input  logic [shac_pkg::VAL_W-1:0]     vendor_limit,
	input  logic [shac_pkg::RAW_W-1:0]     raw_count,
	input  logic                           critical,
	input  logic                           last_attr,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           attr_verdict,
	output logic                           disk_status,
	output logic                           is_final
);
	import shac_pkg::*;

	cfg_t    cfg_q;
	q_port_t push;
	q_port_t head;
	logic    q_full;
	logic    take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rule       <= '0;
			cfg_q.temp_limit <= TEMP_LIMIT_RST;
			cfg_q.use_vendor <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				[REG_RULE_0:REG_RULE_3]: cfg_q.rule[cfg_index[RULE_IDX_W-1:0]] <= rule_t'(cfg_data);
				REG_TEMP_LIMIT:          cfg_q.temp_limit <= cfg_data[VAL_W-1:0];
				REG_USE_VENDOR:          cfg_q.use_vendor <= cfg_data[0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	shac_front #(
		.CUSTOM_RULES(CUSTOM_RULES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.attr_id      (attr_id),
		.norm_value   (norm_value),
		.vendor_limit (vendor_limit),
		.raw_count    (raw_count),
		.critical     (critical),
		.last_attr    (last_attr),
		.push         (push),
		.q_full       (q_full)
	);

	shac_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.take   (take)
	);

	shac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.attr_verdict (attr_verdict),
		.disk_status  (disk_status),
		.is_final     (is_final)
	);

endmodule

### rtl/core/shac_checker.sv
// Port-level assertions for the SMART attribute health check, bound to the top level.
module shac_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic attr_verdict,
	input logic disk_status,
	input logic is_final
);

	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word shown during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable(attr_verdict) && $stable(disk_status) && $stable(is_final))
		else $error("stalled result word changed");

	a_disk_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_final |-> !disk_status)
		else $error("disk verdict set on a word that does not close the run");

	a_final_covers_attr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_final && attr_verdict |-> disk_status)
		else $error("failed closing attribute did not fail the disk");

endmodule

bind smart_attribute_health_check shac_checker u_shac_checker (.*);
